>>> sv/stcf_pkg.sv
// ----------------------------------------------------------------------------
// stcf_pkg: shared constants for the seconds-to-calendar converter
// Field widths, epoch and era constants, fixed-point reciprocals for the
// constant divisions, and the month start table of the March-based year.
// ----------------------------------------------------------------------------
`default_nettype none

package stcf_pkg;

  // Port field widths.
  localparam int unsigned SECS_W  = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // Largest count that still fits 32 bits after the epoch offset is added.
  localparam logic [31:0] MAX_IN_RANGE = 32'd3348282495;
  // Seconds from 1970-01-01 to 2000-01-01.
  localparam logic [31:0] EPOCH_OFFSET = 32'd946684800;

  // A day is 128 * 675 seconds; the low seven bits pass straight through.
  localparam logic [9:0]  DAY_UNITS  = 10'd675;
  localparam logic [15:0] RECIP_675  = 16'd49710;   // floor(2^25 / 675)

  // Era arithmetic. Every count in range falls into era four or five.
  localparam int unsigned DAYS_ZERO_TO_EPOCH = 719468;
  localparam int unsigned DAYS_PER_ERA       = 146097;
  localparam int unsigned FIRST_ERA          = 4;
  localparam int unsigned YEARS_PER_ERA      = 400;
  localparam logic [15:0] ERA_SPLIT_DAY =
    16'((FIRST_ERA + 1) * DAYS_PER_ERA - DAYS_ZERO_TO_EPOCH);
  localparam logic [17:0] LOW_ERA_BIAS =
    18'(DAYS_ZERO_TO_EPOCH - FIRST_ERA * DAYS_PER_ERA);
  localparam logic [11:0] YEAR_BASE_LOW  = 12'(FIRST_ERA * YEARS_PER_ERA);
  localparam logic [11:0] YEAR_BASE_HIGH = 12'((FIRST_ERA + 1) * YEARS_PER_ERA);

  // Leap-day corrections inside an era.
  localparam int unsigned DAYS_PER_CENT_I = 36524;
  localparam logic [17:0] DAYS_PER_4Y   = 18'd1460;
  localparam logic [7:0]  RECIP_1460    = 8'd179;     // floor(2^18 / 1460)
  localparam logic [17:0] LAST_DOE      = 18'd146096;

  // Year of era.
  localparam logic [9:0]  DAYS_PER_YEAR = 10'd365;
  localparam logic [9:0]  RECIP_365     = 10'd718;    // floor(2^18 / 365)

  // Month of the March-based year: (5 * doy + 2) / 153.
  localparam int unsigned MP_DIV    = 153;
  localparam int unsigned MP_COUNT  = 12;
  localparam logic [3:0]  MP_JAN    = 4'd10;

  // Time of day.
  localparam logic [12:0] SECS_PER_HOUR = 13'd3600;
  localparam logic [5:0]  RECIP_3600    = 6'd36;      // floor(2^17 / 3600)
  localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
  localparam logic [6:0]  RECIP_60      = 7'd68;      // floor(2^12 / 60)

  // Day of the March-based year on which a month starts: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

`default_nettype wire

>>> sv/seconds_to_calendar_fields.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_fields: seconds since 2000 to calendar date and time
// Splits a 32-bit count of seconds since 2000-01-01 00:00:00 into Gregorian
// year, month, day of month, hour, minute and second in a 13-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, limited by the output stage: the whole
// pipeline advances whenever the output register is empty or taken.
// Reset (rst_n low, synchronous) clears the stage valid bits only; payload
// registers hold whatever they held and are never shown while invalid.
`default_nettype none

module seconds_to_calendar_fields
  import stcf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SECS_W-1:0]  in_seconds_since_2000,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MONTH_W-1:0]      out_month,
  output logic [DAY_W-1:0]        out_day_of_month,
  output logic [HOUR_W-1:0]       out_hour,
  output logic [MIN_W-1:0]        out_minute,
  output logic [SEC_W-1:0]        out_second,
  output logic                    out_out_of_range
);

  localparam int unsigned NUM_STAGES = 13;

  // One record travels down the pipe. Each stage copies the record of the
  // stage before it and fills in the fields that it computes.
  typedef struct packed {
    logic        oor;      // input beyond the 32-bit range after the offset
    logic [31:0] t;        // seconds since 1970
    logic [15:0] dq;       // day estimate, then whole days
    logic [10:0] drem;     // remainder in 128-second units before correction
    logic [16:0] sod;      // second of the day
    logic [17:0] doe;      // day of era
    logic        era5;     // era five rather than era four
    logic [6:0]  q1460;    // four-year leap corrections
    logic [2:0]  q36524;   // century corrections
    logic        q146096;  // last day of the era
    logic [17:0] n;        // day of era without leap days
    logic [8:0]  yq;       // year of era, estimate then final
    logic [9:0]  yrem;     // year remainder before correction
    logic [8:0]  doy;      // day of the March-based year
    logic [11:0] yr;       // year
    logic [3:0]  mp;       // month of the March-based year
    logic [3:0]  mo;       // calendar month
    logic [4:0]  dy;       // day of month
    logic [4:0]  hh;       // hour, estimate then final
    logic [12:0] hrem;     // seconds into the hour
    logic [5:0]  mi;       // minute, estimate then final
    logic [6:0]  mrem;     // seconds into the minute
    logic [5:0]  ss;       // second
  } stage_t;

  stage_t                 stg_r   [1:NUM_STAGES];
  stage_t                 stg_nxt [1:NUM_STAGES];
  logic [NUM_STAGES:1]    vld_r;
  logic [NUM_STAGES:1]    vld_nxt;
  logic                   adv;

  // The pipe moves as a whole: a stalled output freezes every stage, so no
  // beat is dropped or duplicated, and bubbles simply ride along.
  assign adv      = !vld_r[NUM_STAGES] || out_ready;
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[NUM_STAGES-1:1], in_valid};

  always_comb begin
    logic [40:0] prod2;
    logic [25:0] prod3;
    logic [22:0] prod5;
    logic [25:0] prod6a;
    logic [17:0] prod6b;
    logic [24:0] prod7;
    logic [6:0]  d1460;
    logic [27:0] prod8a;
    logic [18:0] prod8b;
    logic [18:0] prod9a;
    logic [12:0] prod9b;
    logic [1:0]  cent;
    logic [17:0] yday;
    logic [10:0] mpval;
    logic [3:0]  mpcnt;

    // Stage 1: move to the 1970 epoch and flag counts that would overflow.
    stg_nxt[1]     = '0;
    stg_nxt[1].t   = in_seconds_since_2000 + EPOCH_OFFSET;
    stg_nxt[1].oor = in_seconds_since_2000 > MAX_IN_RANGE;

    // Stage 2: days estimate. Since 86400 = 128 * 675, the count shifted by
    // seven bits is divided by 675 through a reciprocal that may come out
    // one short of the true quotient.
    stg_nxt[2]    = stg_r[1];
    prod2         = 41'(stg_r[1].t[31:7]) * 41'(RECIP_675);
    stg_nxt[2].dq = prod2[40:25];

    // Stage 3: remainder of that estimate; it is below 2 * 675, so eleven
    // low bits of the difference hold it exactly.
    stg_nxt[3]      = stg_r[2];
    prod3           = 26'(stg_r[2].dq) * 26'(DAY_UNITS);
    stg_nxt[3].drem = stg_r[2].t[17:7] - prod3[10:0];

    // Stage 4: correct the estimate and assemble the second of the day.
    stg_nxt[4] = stg_r[3];
    if (stg_r[3].drem >= 11'(DAY_UNITS)) begin
      stg_nxt[4].dq  = stg_r[3].dq + 16'd1;
      stg_nxt[4].sod = {10'(stg_r[3].drem - 11'(DAY_UNITS)), stg_r[3].t[6:0]};
    end else begin
      stg_nxt[4].sod = {stg_r[3].drem[9:0], stg_r[3].t[6:0]};
    end

    // Stage 5: day of era. Only eras four and five are reachable, so one
    // compare picks the era. Hour estimate in parallel.
    stg_nxt[5] = stg_r[4];
    if (stg_r[4].dq >= ERA_SPLIT_DAY) begin
      stg_nxt[5].doe  = 18'(stg_r[4].dq) - 18'(ERA_SPLIT_DAY);
      stg_nxt[5].era5 = 1'b1;
    end else begin
      stg_nxt[5].doe  = 18'(stg_r[4].dq) + LOW_ERA_BIAS;
      stg_nxt[5].era5 = 1'b0;
    end
    prod5         = 23'(stg_r[4].sod) * 23'(RECIP_3600);
    stg_nxt[5].hh = prod5[21:17];

    // Stage 6: leap-day correction terms of the day of era, and the
    // remainder of the hour estimate.
    stg_nxt[6]       = stg_r[5];
    prod6a           = 26'(stg_r[5].doe) * 26'(RECIP_1460);
    stg_nxt[6].q1460 = prod6a[24:18];
    stg_nxt[6].q36524 = 3'(stg_r[5].doe >= 18'(DAYS_PER_CENT_I))
                      + 3'(stg_r[5].doe >= 18'(2 * DAYS_PER_CENT_I))
                      + 3'(stg_r[5].doe >= 18'(3 * DAYS_PER_CENT_I))
                      + 3'(stg_r[5].doe >= 18'(4 * DAYS_PER_CENT_I));
    stg_nxt[6].q146096 = stg_r[5].doe >= LAST_DOE;
    prod6b           = 18'(stg_r[5].hh) * 18'(SECS_PER_HOUR);
    stg_nxt[6].hrem  = stg_r[5].sod[12:0] - prod6b[12:0];

    // Stage 7: settle the four-year term and remove the leap days; settle
    // the hour.
    stg_nxt[7] = stg_r[6];
    prod7      = (25'(stg_r[6].q1460) + 25'd1) * 25'(DAYS_PER_4Y);
    if (25'(stg_r[6].doe) >= prod7) begin
      d1460 = stg_r[6].q1460 + 7'd1;
    end else begin
      d1460 = stg_r[6].q1460;
    end
    stg_nxt[7].n = stg_r[6].doe - 18'(d1460) + 18'(stg_r[6].q36524)
                 - 18'(stg_r[6].q146096);
    if (stg_r[6].hrem >= SECS_PER_HOUR) begin
      stg_nxt[7].hh   = stg_r[6].hh + 5'd1;
      stg_nxt[7].hrem = stg_r[6].hrem - SECS_PER_HOUR;
    end

    // Stage 8: year of era estimate and minute estimate.
    stg_nxt[8]    = stg_r[7];
    prod8a        = 28'(stg_r[7].n) * 28'(RECIP_365);
    stg_nxt[8].yq = prod8a[26:18];
    prod8b        = 19'(stg_r[7].hrem[11:0]) * 19'(RECIP_60);
    stg_nxt[8].mi = prod8b[17:12];

    // Stage 9: remainders of both estimates, each below twice its divisor.
    stg_nxt[9]      = stg_r[8];
    prod9a          = 19'(stg_r[8].yq) * 19'(DAYS_PER_YEAR);
    stg_nxt[9].yrem = stg_r[8].n[9:0] - prod9a[9:0];
    prod9b          = 13'(stg_r[8].mi) * 13'(SECS_PER_MIN);
    stg_nxt[9].mrem = stg_r[8].hrem[6:0] - prod9b[6:0];

    // Stage 10: settle year of era, minute and second.
    stg_nxt[10] = stg_r[9];
    if (stg_r[9].yrem >= DAYS_PER_YEAR) begin
      stg_nxt[10].yq = stg_r[9].yq + 9'd1;
    end
    if (stg_r[9].mrem >= SECS_PER_MIN) begin
      stg_nxt[10].mi = stg_r[9].mi + 6'd1;
      stg_nxt[10].ss = 6'(stg_r[9].mrem - SECS_PER_MIN);
    end else begin
      stg_nxt[10].ss = stg_r[9].mrem[5:0];
    end

    // Stage 11: day of the March-based year and the year itself.
    stg_nxt[11] = stg_r[10];
    cent = 2'(stg_r[10].yq >= 9'd100) + 2'(stg_r[10].yq >= 9'd200)
         + 2'(stg_r[10].yq >= 9'd300);
    yday = 18'(stg_r[10].yq) * 18'(DAYS_PER_YEAR) + 18'(stg_r[10].yq[8:2])
         - 18'(cent);
    stg_nxt[11].doy = 9'(stg_r[10].doe - yday);
    stg_nxt[11].yr  = (stg_r[10].era5 ? YEAR_BASE_HIGH : YEAR_BASE_LOW)
                    + 12'(stg_r[10].yq);

    // Stage 12: month of the March-based year as a count of passed
    // month boundaries.
    stg_nxt[12] = stg_r[11];
    mpval = 11'(stg_r[11].doy) * 11'd5 + 11'd2;
    mpcnt = '0;
    for (int j = 1; j < MP_COUNT; j++) begin
      mpcnt = mpcnt + 4'(mpval >= 11'(MP_DIV * j));
    end
    stg_nxt[12].mp = mpcnt;

    // Stage 13: calendar month and day; January and February belong to the
    // next calendar year. Out-of-range beats show all fields as zero.
    stg_nxt[13] = stg_r[12];
    stg_nxt[13].dy = 5'(stg_r[12].doy - month_start(stg_r[12].mp) + 9'd1);
    if (stg_r[12].mp >= MP_JAN) begin
      stg_nxt[13].mo = stg_r[12].mp - 4'd9;
      stg_nxt[13].yr = stg_r[12].yr + 12'd1;
    end else begin
      stg_nxt[13].mo = stg_r[12].mp + 4'd3;
    end
    if (stg_r[12].oor) begin
      stg_nxt[13].yr = '0;
      stg_nxt[13].mo = '0;
      stg_nxt[13].dy = '0;
      stg_nxt[13].hh = '0;
      stg_nxt[13].mi = '0;
      stg_nxt[13].ss = '0;
    end
  end

  // Valid bits: the only state that reset touches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid        = vld_r[NUM_STAGES];
  assign out_year         = stg_r[NUM_STAGES].yr;
  assign out_month        = stg_r[NUM_STAGES].mo;
  assign out_day_of_month = stg_r[NUM_STAGES].dy;
  assign out_hour         = stg_r[NUM_STAGES].hh;
  assign out_minute       = stg_r[NUM_STAGES].mi;
  assign out_second       = stg_r[NUM_STAGES].ss;
  assign out_out_of_range = stg_r[NUM_STAGES].oor;

endmodule

`default_nettype wire

>>> sv/stcf_checker.sv
// ----------------------------------------------------------------------------
// stcf_checker: port-level checks for the seconds-to-calendar converter
// Watches the result channel for legal field values and held beats.
// ----------------------------------------------------------------------------
`default_nettype none

module stcf_checker
  import stcf_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [YEAR_W-1:0]  out_year,
  input wire logic [MONTH_W-1:0] out_month,
  input wire logic [DAY_W-1:0]   out_day_of_month,
  input wire logic [HOUR_W-1:0]  out_hour,
  input wire logic [MIN_W-1:0]   out_minute,
  input wire logic [SEC_W-1:0]   out_second,
  input wire logic               out_out_of_range
);

  // No result beat is shown in the cycle after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // An out-of-range beat carries all date and time fields as zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_year == '0 && out_month == '0 && out_day_of_month == '0 &&
      out_hour == '0 && out_minute == '0 && out_second == '0)
    else $error("out-of-range beat with nonzero fields");

  // An in-range beat carries fields in legal ranges; day of month is >= 1.
  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_year >= 12'd2000 && out_year <= 12'd2106 &&
      out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day_of_month >= 5'd1 &&
      out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59)
    else $error("result beat with an illegal date or time");

  // A result beat that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_year) && $stable(out_month) &&
      $stable(out_day_of_month) && $stable(out_hour) &&
      $stable(out_minute) && $stable(out_second) && $stable(out_out_of_range))
    else $error("stalled result beat changed or dropped");

endmodule

bind seconds_to_calendar_fields stcf_checker u_stcf_checker (.*);

`default_nettype wire
